>>> src/lirs_pkg.sv
package lirs_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 24;
   localparam int FRAC_BITS_DEFAULT    = 24;
   localparam int MAX_BURST_DEFAULT    = 16;

   // Configuration register widths are fixed by the register map.
   localparam int STEP_WIDTH      = 32;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   // Words held between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_STEP   = 1'b0,
      CSR_BYPASS = 1'b1
   } csr_index_type;

endpackage

>>> src/lirs_queue.sv
module lirs_queue import lirs_pkg::*; #(
   parameter int WIDTH = 49,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/lirs_front.sv
module lirs_front import lirs_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_WIDTH-1:0]   req_sample_in,
   input  logic                      bypass,
   input  logic                      step_zero,
   input  logic                      queue_full,
   output logic                      push,
   output logic [2*SAMPLE_WIDTH:0]   push_data
);

   logic                    accept;
   logic                    have_ff, have_in;
   logic [SAMPLE_WIDTH-1:0] prev_ff, prev_in;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Bypass words and interpolation words go to the back; a zero step drops
   // the word and the first sample after reset is only stored.
   always_comb begin
      have_in   = have_ff;
      prev_in   = prev_ff;
      push      = 1'b0;
      push_data = {bypass, req_sample_in, prev_ff};
      if (accept) begin
         if (bypass) begin
            push = 1'b1;
         end else if (!step_zero) begin
            have_in = 1'b1;
            prev_in = req_sample_in;
            push    = have_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         have_ff <= have_in;
         prev_ff <= prev_in;
      end
   end

endmodule

>>> src/lirs_back.sv
module lirs_back import lirs_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int FRAC_BITS    = FRAC_BITS_DEFAULT,
   parameter int MAX_BURST    = MAX_BURST_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  logic [2*SAMPLE_WIDTH:0] head_data,
   output logic                    head_pop,
   input  logic [STEP_WIDTH-1:0]   step,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                    rsp_last_of_run
);

   localparam int PH_W   = FRAC_BITS + 8;
   localparam int SUM_W  = ((PH_W > STEP_WIDTH) ? PH_W : STEP_WIDTH) + 1;
   localparam int CNT_W  = $clog2(MAX_BURST + 1);
   localparam int PROD_W = SAMPLE_WIDTH + FRAC_BITS + 2;
   localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(1) << FRAC_BITS;
   localparam logic [PH_W-1:0] PHASE_MAX = {PH_W{1'b1}};

   logic                    is_bypass;
   logic [SAMPLE_WIDTH-1:0] cur, prev;
   logic [PH_W-1:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]        phase_sum;
   logic [PH_W-1:0]         phase_sat, phase_consumed;
   logic                    below_one, burst_end;
   logic                    issue, issue_last;

   logic signed [SAMPLE_WIDTH:0] diff;
   logic signed [FRAC_BITS:0]    frac;
   logic signed [PROD_W-1:0]     prod;

   // Product stage, then the output register.
   logic                     p_valid_ff, p_valid_in;
   logic                     p_bypass_ff;
   logic                     p_last_ff;
   logic [SAMPLE_WIDTH-1:0]  p_base_ff;
   logic signed [PROD_W-1:0] p_prod_ff;
   logic                     o_valid_ff, o_valid_in;
   logic [SAMPLE_WIDTH-1:0]  o_sample_ff;
   logic                     o_last_ff;
   logic                     o_adv, p_free;

   logic signed [PROD_W-1:0]     shifted;
   logic signed [SAMPLE_WIDTH+1:0] interp;

   assign is_bypass = head_data[2*SAMPLE_WIDTH];
   assign cur       = head_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign prev      = head_data[SAMPLE_WIDTH-1:0];

   assign o_adv  = !o_valid_ff || !rsp_stall;
   assign p_free = !p_valid_ff || o_adv;

   assign below_one      = (phase_ff < PHASE_ONE);
   assign phase_sum      = SUM_W'(phase_ff) + SUM_W'(step);
   assign phase_sat      = (phase_sum > SUM_W'(PHASE_MAX)) ? PHASE_MAX : phase_sum[PH_W-1:0];
   assign burst_end      = (phase_sat >= PHASE_ONE) || (cnt_ff == CNT_W'(MAX_BURST - 1));
   // The consume step of a word is folded into its last result.
   assign phase_consumed = (phase_sat >= PHASE_ONE) ? phase_sat - PHASE_ONE : '0;

   assign diff = $signed({cur[SAMPLE_WIDTH-1], cur}) - $signed({prev[SAMPLE_WIDTH-1], prev});
   assign frac = $signed({1'b0, phase_ff[FRAC_BITS-1:0]});
   assign prod = diff * frac;

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      issue      = 1'b0;
      issue_last = 1'b0;
      head_pop   = 1'b0;
      if (head_valid && p_free) begin
         if (is_bypass) begin
            issue      = 1'b1;
            issue_last = 1'b1;
            head_pop   = 1'b1;
         end else if (below_one) begin
            issue = 1'b1;
            if (burst_end) begin
               issue_last = 1'b1;
               head_pop   = 1'b1;
               cnt_in     = '0;
               phase_in   = phase_consumed;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               phase_in = phase_sat;
            end
         end else begin
            // Phase already past this interval: the sample is skipped.
            head_pop = 1'b1;
            phase_in = phase_ff - PHASE_ONE;
         end
      end
   end

   assign p_valid_in = issue || (p_valid_ff && !o_adv);
   assign o_valid_in = o_adv ? p_valid_ff : o_valid_ff;

   // Arithmetic shift gives the floor of the scaled product.
   assign shifted = p_prod_ff >>> FRAC_BITS;
   assign interp  = $signed({{2{p_base_ff[SAMPLE_WIDTH-1]}}, p_base_ff})
                  + $signed(shifted[SAMPLE_WIDTH+1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         cnt_ff     <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
      if (issue) begin
         p_bypass_ff <= is_bypass;
         p_last_ff   <= issue_last;
         p_base_ff   <= is_bypass ? cur : prev;
         p_prod_ff   <= prod;
      end
      if (o_adv && p_valid_ff) begin
         o_sample_ff <= p_bypass_ff ? p_base_ff : interp[SAMPLE_WIDTH-1:0];
         o_last_ff   <= p_last_ff;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_sample_out  = o_sample_ff;
   assign rsp_last_of_run = o_last_ff;

endmodule

>>> src/linear_interp_resampler_unit.sv
// Linear-interpolation sample-rate converter for one mono channel.
// Input words (req_) carry one signed sample each; result words (rsp_)
// carry an output sample and last_of_run, set on the final result that an
// input word causes. Both channels move a word when valid is high and
// stall is low.
// The csr_ port writes step (index 0, rate ratio with FRAC_BITS fraction
// bits) and bypass (index 1); write it only while the block is idle.
// Input words enter a two-word queue and are taken whenever it has room,
// also while a result waits on a stalled receiver. The back end emits one
// result per cycle while the receiver does not stall, up to MAX_BURST per
// input word; a bypass word gives one result, and a word whose phase is
// already past its interval gives none and is skipped. A result passes
// through the queue, then the product register, then the output register.
// A stalled receiver holds the output word; the back end fills its product
// register and then waits, and the queue stalls the input once full.
// Reset clears the phase, the stored sample and all queued words, and sets
// step to 1.0 and bypass to 0.
module linear_interp_resampler_unit import lirs_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int FRAC_BITS    = FRAC_BITS_DEFAULT,
   parameter int MAX_BURST    = MAX_BURST_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_WIDTH-1:0]    req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [SAMPLE_WIDTH-1:0]    rsp_sample_out,
   output logic                       rsp_last_of_run,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int QW = 2 * SAMPLE_WIDTH + 1;

   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  bypass_ff, bypass_in;
   logic                  queue_full, push, head_valid, head_pop;
   logic [QW-1:0]         push_data, head_data;

   always_comb begin
      step_in   = step_ff;
      bypass_in = bypass_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_STEP:   step_in   = csr_wdata[STEP_WIDTH-1:0];
            CSR_BYPASS: bypass_in = csr_wdata[0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_WIDTH'(1) << FRAC_BITS;
         bypass_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         bypass_ff <= bypass_in;
      end
   end

   lirs_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_in(req_sample_in),
      .bypass       (bypass_ff),
      .step_zero    (step_ff == '0),
      .queue_full   (queue_full),
      .push         (push),
      .push_data    (push_data)
   );

   lirs_queue #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (head_pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   lirs_back #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .MAX_BURST   (MAX_BURST)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .head_pop       (head_pop),
      .step           (step_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

>>> src/lirs_checker.sv
module lirs_checker import lirs_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int MAX_BURST    = MAX_BURST_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                    rsp_last_of_run
);

   localparam int RUN_W = $clog2(MAX_BURST + 1);

   logic [RUN_W-1:0] run_ff, run_in;

   // Results delivered so far in the current run.
   always_comb begin
      run_in = run_ff;
      if (rsp_valid && !rsp_stall) begin
         run_in = rsp_last_of_run ? '0 : run_ff + RUN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out)
                                 && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

   a_burst_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (run_ff == RUN_W'(MAX_BURST - 1)) |-> rsp_last_of_run)
      else $error("run of results longer than the burst limit");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_ff < RUN_W'(MAX_BURST))
      else $error("result run count out of range");

endmodule

bind linear_interp_resampler_unit lirs_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH),
   .MAX_BURST   (MAX_BURST)
) u_lirs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .rsp_last_of_run(rsp_last_of_run)
);
